// ----- sv/lyndon_factorization_assert.svh -----
// ----------------------------------------------------------------------------
// lyndon_factorization_assert.svh
// Assertion macros for the Lyndon factorization block; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LYNDON_FACTORIZATION_ASSERT_SVH
`define LYNDON_FACTORIZATION_ASSERT_SVH

`ifndef SYNTHESIS
`define LF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define LF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `LF_ASSERT(label, clk, rst_n, !(expr), msg)
`else
`define LF_ASSERT(label, clk, rst_n, prop, msg)
`define LF_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ----- sv/lf_pkg.sv -----
// ----------------------------------------------------------------------------
// lf_pkg
// Shared widths, defaults and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package lf_pkg;

    localparam int SYM_W       = 8;
    localparam int START_W     = 6;
    localparam int LEN_W       = 7;   // pointers, fill count and lengths
    localparam int MAX_LEN_DEF = 64;

    // controller -> datapath
    typedef struct packed {
        logic load;          // accept a byte (store or flag overflow)
        logic clear;         // end of string: reset fill, overflow, pointers
        logic outer_init;    // j = i + 1, k = i
        logic issue_read;    // read text[k] and text[j]
        logic step;          // advance j and k from registered compare
        logic latch_period;  // period = j - k
        logic emit_step;     // load output register, i += period
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic i_lt_n;
        logic j_lt_n;
        logic k_le_j;        // text[k] <= text[j]
        logic i_le_k;
        logic out_free;      // output register can take a transaction
    } status_t;

endpackage

`default_nettype wire

// ----- sv/lf_if.sv -----
// ----------------------------------------------------------------------------
// lf_sym_if / lf_fac_if
// Valid/ready channels for input bytes and for emitted factors.
// ----------------------------------------------------------------------------
`default_nettype none

interface lf_sym_if;
    logic                      valid;
    logic                      ready;
    logic [lf_pkg::SYM_W-1:0]  symbol;
    logic                      end_of_string;

    modport source (output valid, output symbol, output end_of_string, input ready);
    modport sink   (input valid, input symbol, input end_of_string, output ready);
endinterface

interface lf_fac_if;
    logic                       valid;
    logic                       ready;
    logic [lf_pkg::START_W-1:0] factor_start;
    logic [lf_pkg::LEN_W-1:0]   factor_length;
    logic                       last_factor;
    logic                       overflow;

    modport source (output valid, output factor_start, output factor_length,
                    output last_factor, output overflow, input ready);
    modport sink   (input valid, input factor_start, input factor_length,
                    input last_factor, input overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/lf_dp.sv -----
// ----------------------------------------------------------------------------
// lf_dp
// Datapath: text buffer, scan pointers, period and factor output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lyndon_factorization_assert.svh"

module lf_dp #(
    parameter int MAX_LEN = lf_pkg::MAX_LEN_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lf_pkg::cmd_t             cmd,
    output lf_pkg::status_t               status,
    input  wire logic [lf_pkg::SYM_W-1:0] symbol,
    lf_fac_if.source                      factors
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [lf_pkg::LEN_W-1:0] FILL_MAX = lf_pkg::LEN_W'(MAX_LEN);

    logic [lf_pkg::SYM_W-1:0] text_mem [MAX_LEN];
    logic [lf_pkg::SYM_W-1:0] rd_k_reg, rd_j_reg;

    logic [lf_pkg::LEN_W-1:0] fill_reg, fill_next;
    logic                     ovf_reg, ovf_next;
    logic [lf_pkg::LEN_W-1:0] i_reg, i_next;
    logic [lf_pkg::LEN_W-1:0] j_reg, j_next;
    logic [lf_pkg::LEN_W-1:0] k_reg, k_next;
    logic [lf_pkg::LEN_W-1:0] period_reg, period_next;
    logic                     out_valid_reg, out_valid_next;

    logic [lf_pkg::START_W-1:0] start_reg;
    logic [lf_pkg::LEN_W-1:0]   length_reg;
    logic                       last_reg, ovf_out_reg;

    logic                     full;
    logic [lf_pkg::LEN_W-1:0] i_plus_p;

    assign full     = (fill_reg == FILL_MAX);
    assign i_plus_p = i_reg + period_reg;

    // buffer write
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            text_mem[fill_reg[AW-1:0]] <= symbol;
        end
    end

    // two registered reads per compare
    always_ff @(posedge clk)
    begin
        if (cmd.issue_read)
        begin
            rd_k_reg <= text_mem[k_reg[AW-1:0]];
            rd_j_reg <= text_mem[j_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        period_next    = period_reg;
        out_valid_next = out_valid_reg && !factors.ready;

        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (cmd.clear)
        begin
            fill_next = '0;
            ovf_next  = 1'b0;
            i_next    = '0;
            j_next    = '0;
            k_next    = '0;
        end
        if (cmd.outer_init)
        begin
            j_next = i_reg + 1'b1;
            k_next = i_reg;
        end
        if (cmd.step)
        begin
            k_next = (rd_k_reg < rd_j_reg) ? i_reg : k_reg + 1'b1;
            j_next = j_reg + 1'b1;
        end
        if (cmd.latch_period)
        begin
            period_next = j_reg - k_reg;
        end
        if (cmd.emit_step)
        begin
            i_next         = i_plus_p;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            period_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // factor payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            start_reg   <= i_reg[lf_pkg::START_W-1:0];
            length_reg  <= period_reg;
            last_reg    <= (i_plus_p >= fill_reg);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign status.i_lt_n   = (i_reg < fill_reg);
    assign status.j_lt_n   = (j_reg < fill_reg);
    assign status.k_le_j   = (rd_k_reg <= rd_j_reg);
    assign status.i_le_k   = (i_reg <= k_reg);
    assign status.out_free = !out_valid_reg || factors.ready;

    assign factors.valid         = out_valid_reg;
    assign factors.factor_start  = start_reg;
    assign factors.factor_length = length_reg;
    assign factors.last_factor   = last_reg;
    assign factors.overflow      = ovf_out_reg;

    `LF_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FILL_MAX, "fill count beyond capacity")
    `LF_ASSERT(a_read_order, clk, rst_n, cmd.issue_read |-> (k_reg < j_reg), "match not behind probe")
    `LF_ASSERT(a_emit_period, clk, rst_n, cmd.emit_step |-> (period_reg != '0), "zero-length factor")
    `LF_ASSERT(a_clear_fill, clk, rst_n, cmd.clear |=> (fill_reg == '0 && i_reg == '0), "clear did not take")

endmodule

`default_nettype wire

// ----- sv/lf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lf_ctrl
// Controller: sequences load, Duval scan rounds and factor emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lyndon_factorization_assert.svh"

module lf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_eos,
    output logic                 in_ready,
    output lf_pkg::cmd_t         cmd,
    input  wire lf_pkg::status_t status
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_OUTER = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_eos)
                    begin
                        state_next = ST_OUTER;
                    end
                end
            end
            ST_OUTER:
            begin
                if (status.i_lt_n)
                begin
                    cmd.outer_init = 1'b1;
                    state_next     = ST_READ;
                end
                else
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_READ:
            begin
                if (status.j_lt_n)
                begin
                    cmd.issue_read = 1'b1;
                    state_next     = ST_CMP;
                end
                else
                begin
                    cmd.latch_period = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_CMP:
            begin
                if (status.k_le_j)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.latch_period = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.i_le_k)
                begin
                    state_next = ST_OUTER;
                end
                else if (status.out_free)
                begin
                    cmd.emit_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LF_ASSERT(a_eos_starts_scan, clk, rst_n, (in_valid && in_ready && in_eos) |=> (state_reg == ST_OUTER), "scan did not start")
    `LF_ASSERT_NEVER(a_emit_without_room, clk, rst_n, cmd.emit_step && !status.out_free, "emit into busy output")

endmodule

`default_nettype wire

// ----- sv/lyndon_factorization.sv -----
// ----------------------------------------------------------------------------
// lyndon_factorization
// Lyndon factorization of a byte string by Duval's three-pointer scan.
// ----------------------------------------------------------------------------
// Usage:
//  - text: one byte per transaction (symbol, end_of_string). Bytes load at one
//    per cycle while loading into a MAX_LEN-byte buffer; bytes past capacity
//    are dropped; the overflow flag is raised for every factor of that string.
//  - The transaction carrying end_of_string starts the scan; text.ready stays
//    low until the last factor is emitted and the buffer has been cleared.
//  - factors: one transaction per Lyndon factor, in order, as factor_start /
//    factor_length, with last_factor marking the final one.
//  - Scan: each round opens with an outer step, then alternates a registered
//    dual read and a compare while the probe advances, latches the period
//    and emits the factors one by one; a clear ends the string.
//  - Stall: factors has a single output register; while it is full and the
//    receiver holds ready low, emission waits and the scan holds its state.
//  - Reset: asynchronous, active low; returns to loading with an empty buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module lyndon_factorization #(
    parameter int MAX_LEN = lf_pkg::MAX_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lf_sym_if.sink    text,
    lf_fac_if.source  factors
);

    lf_pkg::cmd_t    cmd;
    lf_pkg::status_t status;

    // sequencer: load / outer round / read / compare / emit
    lf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_eos   (text.end_of_string),
        .in_ready (text.ready),
        .cmd      (cmd),
        .status   (status)
    );

    // buffer, pointers i/j/k, period and factor output register
    lf_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .symbol  (text.symbol),
        .factors (factors)
    );

endmodule

`default_nettype wire
